// ----- rtl/m3inv_pkg.sv -----
// Shared types and constant index tables for the 3x3 matrix inverse unit.
package m3inv_pkg;

    localparam int NUM_ELEMS = 9;
    localparam int NUM_PRODS = 18;
    localparam int THR_BITS  = 31;
    localparam logic [THR_BITS-1:0] THR_RESET = 31'd66;

    typedef logic [3:0] idx_t;

    // Cofactor i is PROD(2i) - PROD(2i+1); each product is element A times element B.
    // Sign flips of the odd cofactors are folded into the operand order.
    localparam idx_t PROD_A [NUM_PRODS] = '{
        4'd4, 4'd5, 4'd5, 4'd3, 4'd3, 4'd4, 4'd2, 4'd1, 4'd0,
        4'd2, 4'd1, 4'd0, 4'd1, 4'd2, 4'd2, 4'd0, 4'd0, 4'd1
    };
    localparam idx_t PROD_B [NUM_PRODS] = '{
        4'd8, 4'd7, 4'd6, 4'd8, 4'd7, 4'd6, 4'd7, 4'd8, 4'd8,
        4'd6, 4'd6, 4'd7, 4'd5, 4'd4, 4'd3, 4'd5, 4'd4, 4'd3
    };

    // Result element at row r, column c comes from cofactor at row c, column r.
    localparam idx_t TRANSPOSE [NUM_ELEMS] = '{
        4'd0, 4'd3, 4'd6, 4'd1, 4'd4, 4'd7, 4'd2, 4'd5, 4'd8
    };

endpackage

// ----- rtl/matrix3_inverse_unit.sv -----
// Pipelined 3x3 matrix inverse by the adjugate in signed fixed point.
//
// One matrix per transfer on the s_ channel, one inverse per transfer on the m_ channel,
// in order, one item per clock while m_ does not stall. Eight stages form the products,
// cofactors, determinant and the dividend, then a restoring divider that retires one
// quotient bit per stage for all nine elements in parallel sets the depth, and a last
// stage applies the sign, saturates, transposes and holds the result. The
// pipeline advances as a whole whenever the output register is empty or being taken, so
// a stall on m_ freezes every stage and nothing is lost or repeated. Each element is the
// transposed cofactor divided by the determinant, rounded to nearest with ties away from
// zero and saturated to the element range. When the determinant is zero or its magnitude
// is below singular_threshold (same fixed-point format as the elements), m_tuser is set
// and all elements are zero. The threshold is written through cfg_wr_en / cfg_wr_data
// and should only change while no transfer is in flight.
module matrix3_inverse_unit
    import m3inv_pkg::*;
#(
    parameter int ELEM_BITS = 32,
    parameter int FRAC_BITS = 16
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    // Fields from bit 0 up: a00, a01, a02, a10, a11, a12, a20, a21, a22, zero padding.
    input  logic [((9*ELEM_BITS+7)/8)*8-1:0] s_tdata,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    // Fields from bit 0 up: b00, b01, b02, b10, b11, b12, b20, b21, b22, zero padding.
    output logic [((9*ELEM_BITS+7)/8)*8-1:0] m_tdata,
    // Fields from bit 0 up: singular.
    output logic [0:0]            m_tuser,
    input  logic                  cfg_wr_en,
    input  logic [THR_BITS-1:0]   cfg_wr_data
);

    localparam int E      = ELEM_BITS;
    localparam int F      = FRAC_BITS;
    localparam int DATA_W = ((9*ELEM_BITS+7)/8)*8;
    localparam int PW     = 2*E;          // 2x2 product
    localparam int CW     = 2*E + 1;      // cofactor
    localparam int HW     = 2*E + 1;      // partial product of the determinant
    localparam int DW     = 3*E + 3;      // determinant
    localparam int TW     = THR_BITS + 2*F;
    localparam int CMPW   = ((DW > TW) ? DW : TW) + 2;
    localparam int RW     = ((DW+E+1) > (CW+2*F+2) ? (DW+E+1) : (CW+2*F+2)) + 1;
    localparam int NV     = E + 9;        // stages holding a valid bit

    logic [NV-1:0] v_reg;
    logic          en;
    logic [THR_BITS-1:0] thr_reg;

    // The whole pipeline moves when the output register can take a new item.
    assign en       = m_tready || !v_reg[NV-1];
    assign s_tready = en;
    assign m_tvalid = v_reg[NV-1];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg   <= '0;
            thr_reg <= THR_RESET;
        end else begin
            if (en) begin
                v_reg <= {v_reg[NV-2:0], s_tvalid};
            end
            if (cfg_wr_en) begin
                thr_reg <= cfg_wr_data;
            end
        end
    end

    // Stage 1: capture the matrix.
    logic signed [E-1:0]  m1_reg  [NUM_ELEMS];
    // Stage 2: the eighteen 2x2 products, plus row 0 kept for the determinant.
    logic signed [PW-1:0] p2_reg  [NUM_PRODS];
    logic signed [E-1:0]  top2_reg [3];
    // Stage 3: exact cofactors.
    logic signed [CW-1:0] c3_reg  [NUM_ELEMS];
    logic signed [E-1:0]  top3_reg [3];
    // Stage 4: the row 0 expansion split into low and high partial products.
    logic signed [HW-1:0] lo4_reg [3];
    logic signed [HW-1:0] hi4_reg [3];
    logic signed [CW-1:0] c4_reg  [NUM_ELEMS];
    // Stage 5: recombined terms.
    logic signed [DW-1:0] t5_reg  [3];
    logic signed [CW-1:0] c5_reg  [NUM_ELEMS];
    // Stage 6: determinant.
    logic signed [DW-1:0] det6_reg;
    logic signed [CW-1:0] c6_reg  [NUM_ELEMS];
    // Stage 7: magnitudes, result signs and the singular decision.
    logic [DW-1:0]        adet7_reg;
    logic [CW-1:0]        acof7_reg [NUM_ELEMS];
    logic                 neg7_reg  [NUM_ELEMS];
    logic                 sing7_reg;
    logic signed [CMPW-1:0] det_ext;
    logic signed [CMPW-1:0] thr_ext;

    // Divider: index 0 holds the dividend and divisor, index j has retired j quotient bits.
    logic [RW-1:0] r_reg   [E+1][NUM_ELEMS];
    logic [E-1:0]  q_reg   [E+1][NUM_ELEMS];
    logic          ovf_reg [E+1][NUM_ELEMS];
    logic          neg_reg [E+1][NUM_ELEMS];
    logic [RW-1:0] dd_reg  [E+1];
    logic          sing_reg [E+1];

    logic [9*E-1:0] out_next;
    logic [9*E-1:0] out_data_reg;
    logic           out_sing_reg;

    assign det_ext = CMPW'(det6_reg);
    assign thr_ext = CMPW'({thr_reg, {(2*F){1'b0}}});

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int i = 0; i < NUM_ELEMS; i++) begin
                m1_reg[i] <= s_tdata[i*E +: E];
            end

            for (int j = 0; j < NUM_PRODS; j++) begin
                p2_reg[j] <= m1_reg[PROD_A[j]] * m1_reg[PROD_B[j]];
            end
            for (int i = 0; i < 3; i++) begin
                top2_reg[i] <= m1_reg[i];
                top3_reg[i] <= top2_reg[i];
            end

            for (int i = 0; i < NUM_ELEMS; i++) begin
                c3_reg[i] <= CW'(p2_reg[2*i]) - CW'(p2_reg[2*i+1]);
                c4_reg[i] <= c3_reg[i];
                c5_reg[i] <= c4_reg[i];
                c6_reg[i] <= c5_reg[i];
            end

            // det = sum of m0i * c0i, with each cofactor cut into a signed high and an
            // unsigned low half so that each multiplier takes an element times a value of E+1 bits.
            for (int i = 0; i < 3; i++) begin
                lo4_reg[i] <= top3_reg[i] * $signed({1'b0, c3_reg[i][E-1:0]});
                hi4_reg[i] <= top3_reg[i] * $signed(c3_reg[i][CW-1:E]);
                t5_reg[i]  <= (DW'(hi4_reg[i]) <<< E) + DW'(lo4_reg[i]);
            end

            det6_reg <= t5_reg[0] + t5_reg[1] + t5_reg[2];

            adet7_reg <= det6_reg[DW-1] ? DW'(-det6_reg) : DW'(det6_reg);
            sing7_reg <= (det_ext == '0) || ((det_ext < thr_ext) && (det_ext > -thr_ext));
            for (int i = 0; i < NUM_ELEMS; i++) begin
                acof7_reg[i] <= c6_reg[i][CW-1] ? CW'(-c6_reg[i]) : CW'(c6_reg[i]);
                neg7_reg[i]  <= c6_reg[i][CW-1] ^ det6_reg[DW-1];
            end

            // Rounded quotient is floor((2|c| * 2^2F + |D|) / (2|D|)).
            dd_reg[0]   <= RW'(adet7_reg) << 1;
            sing_reg[0] <= sing7_reg;
            for (int i = 0; i < NUM_ELEMS; i++) begin
                r_reg[0][i]   <= (RW'(acof7_reg[i]) << (2*F+1)) + RW'(adet7_reg);
                q_reg[0][i]   <= '0;
                ovf_reg[0][i] <= 1'b0;
                neg_reg[0][i] <= neg7_reg[i];
            end

            out_data_reg <= out_next;
            out_sing_reg <= sing_reg[E];
        end
    end

    // One restoring step per stage, quotient bit E-j at stage j.
    for (genvar j = 1; j <= E; j++) begin : g_div
        logic [RW-1:0] sub_val;
        assign sub_val = dd_reg[j-1] << (E-j);

        always_ff @(posedge aclk) begin
            if (en) begin
                dd_reg[j]   <= dd_reg[j-1];
                sing_reg[j] <= sing_reg[j-1];
                for (int i = 0; i < NUM_ELEMS; i++) begin
                    neg_reg[j][i] <= neg_reg[j-1][i];
                    if (r_reg[j-1][i] >= sub_val) begin
                        r_reg[j][i] <= r_reg[j-1][i] - sub_val;
                        q_reg[j][i] <= q_reg[j-1][i] | (E'(1) << (E-j));
                    end else begin
                        r_reg[j][i] <= r_reg[j-1][i];
                        q_reg[j][i] <= q_reg[j-1][i];
                    end
                    if (j == 1) begin
                        // Quotient needs more than E bits: saturate regardless.
                        ovf_reg[j][i] <= r_reg[j-1][i] >= (dd_reg[j-1] << E);
                    end else begin
                        ovf_reg[j][i] <= ovf_reg[j-1][i];
                    end
                end
            end
        end
    end

    // Apply the sign, saturate and transpose into the output fields.
    always_comb begin
        logic [E-1:0] mag;
        logic         ng;
        logic         ov;
        out_next = '0;
        for (int i = 0; i < NUM_ELEMS; i++) begin
            mag = q_reg[E][TRANSPOSE[i]];
            ng  = neg_reg[E][TRANSPOSE[i]];
            ov  = ovf_reg[E][TRANSPOSE[i]];
            if (sing_reg[E]) begin
                out_next[i*E +: E] = '0;
            end else if (!ng) begin
                out_next[i*E +: E] = (ov || mag[E-1]) ? {1'b0, {(E-1){1'b1}}} : mag;
            end else begin
                out_next[i*E +: E] = (ov || (mag[E-1] && (|mag[E-2:0])))
                                     ? {1'b1, {(E-1){1'b0}}} : (~mag + E'(1));
            end
        end
    end

    assign m_tdata = DATA_W'(out_data_reg);
    assign m_tuser = out_sing_reg;

    // A singular result carries all-zero elements.
    a_sing_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[0] |-> out_data_reg == '0)
        else $error("singular result with nonzero elements");

    // A stall freezes the valid bits of every stage.
    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        !en |=> $stable(v_reg))
        else $error("pipeline moved during a stall");

    // A zero determinant is always flagged singular.
    a_zero_det: assert property (@(posedge aclk) disable iff (!aresetn)
        v_reg[5] && en && det6_reg == '0 |=> sing7_reg)
        else $error("zero determinant not flagged singular");

    // After the last step the remainder is below the divisor for a regular item.
    a_div_rem: assert property (@(posedge aclk) disable iff (!aresetn)
        v_reg[E+7] && !sing_reg[E] && !ovf_reg[E][0] |-> r_reg[E][0] < dd_reg[E])
        else $error("divider remainder out of range");

endmodule
